// File: src/nlt_pkg.sv
// Shared types and constants of the named lock table.
`default_nettype none
package nlt_pkg;

    localparam int unsigned NAME_W = 64;
    localparam int unsigned STATUS_W = 3;

    localparam logic [NAME_W-1:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

    localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REL_IDLE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REL_WAKE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

    localparam logic [1:0] LW_FREE   = 2'd0;
    localparam logic [1:0] LW_LOCKED = 2'd1;
    localparam logic [1:0] LW_WAIT   = 2'd2;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic              used;
        logic [1:0]        lw;
        logic [NAME_W-1:0] name;
    } nlt_entry_t;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic hash0;
        logic hash1;
        logic hash2;
        logic rd;
        logic advance;
        logic finish;
    } nlt_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic hit;
        logic empty;
        logic last_probe;
        logic out_free;
    } nlt_stat_t;

endpackage
`default_nettype wire

// File: src/nlt_req_if.sv
// Request channel: command and lock name.
`default_nettype none
interface nlt_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [63:0] lock_name;

    modport source (output valid, output cmd, output lock_name, input ready);
    modport sink (input valid, input cmd, input lock_name, output ready);
endinterface
`default_nettype wire

// File: src/nlt_rsp_if.sv
// Response channel: status and slot index.
`default_nettype none
interface nlt_rsp_if #(
    parameter int unsigned INDEX_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            status;
    logic [INDEX_BITS-1:0] slot_index;

    modport source (output valid, output status, output slot_index, input ready);
    modport sink (input valid, input status, input slot_index, output ready);
endinterface
`default_nettype wire

// File: src/named_lock_table.sv
// Top level: hashed lock table keyed by 64-bit names, linear probing.
// From request transfer to response valid: hash steps S_HASH0 to S_HASH2 on the shared 32x32
// hash multiplier, S_RD and S_CMP on the RAM read port for each probe (1 to 2^INDEX_BITS), S_DONE.
// A new request is taken in S_IDLE, once the previous result is loaded into the response register.
// After reset a clearing pass over all 2^INDEX_BITS slots (1024 by default) holds req.ready low.
// The response register lets a new request in while the previous result waits.
`default_nettype none
module named_lock_table
    import nlt_pkg::*;
#(
    parameter int unsigned INDEX_BITS = 10
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    nlt_req_if.sink    req,
    nlt_rsp_if.source  rsp
);

    nlt_cmd_t  cmd;
    nlt_stat_t stat;

    nlt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nlt_dp #(
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_cmd     (req.cmd),
        .in_name    (req.lock_name),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_status (rsp.status),
        .out_slot   (rsp.slot_index)
    );

endmodule
`default_nettype wire

// File: src/nlt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module nlt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: src/nlt_ctrl.sv
// Sequencer: clearing pass, hash steps, probe walk and result hand-off.
`default_nettype none
module nlt_ctrl
    import nlt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire nlt_stat_t stat,
    output nlt_cmd_t       cmd
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_HASH0 = 8'b0000_0100,
        S_HASH1 = 8'b0000_1000,
        S_HASH2 = 8'b0001_0000,
        S_RD    = 8'b0010_0000,
        S_CMP   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_HASH0;
                end
            end
            S_HASH0:
            begin
                cmd.hash0  = 1'b1;
                state_next = S_HASH1;
            end
            S_HASH1:
            begin
                cmd.hash1  = 1'b1;
                state_next = S_HASH2;
            end
            S_HASH2:
            begin
                cmd.hash2  = 1'b1;
                state_next = S_RD;
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (stat.hit || stat.empty || stat.last_probe)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: src/nlt_dp.sv
// Datapath: hash unit, probe pointer, table memory and result register.
`default_nettype none
module nlt_dp
    import nlt_pkg::*;
#(
    parameter int unsigned INDEX_BITS = 10
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire nlt_cmd_t                cmd,
    output nlt_stat_t                    stat,
    input  wire logic                    in_cmd,
    input  wire logic [NAME_W-1:0]       in_name,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic      [STATUS_W-1:0]     out_status,
    output logic      [INDEX_BITS-1:0]   out_slot
);

    localparam int unsigned TABLE_SIZE = 1 << INDEX_BITS;

    logic                  cmd_reg;
    logic [NAME_W-1:0]     name_reg;
    logic [31:0]           prod_reg;
    logic [31:0]           sum_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [INDEX_BITS-1:0] cnt_reg;
    logic [INDEX_BITS-1:0] clr_reg;
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [INDEX_BITS-1:0] out_slot_reg;

    logic [31:0]           mul_a;
    logic [31:0]           mul_b;
    logic [63:0]           mul_p;
    logic [31:0]           hash_sum;

    nlt_entry_t            rd_entry;
    nlt_entry_t            wr_entry;
    logic                  we;
    logic [INDEX_BITS-1:0] waddr;
    logic                  do_write;
    logic [1:0]            new_lw;
    logic [STATUS_W-1:0]   res_status;
    logic                  res_slot_ok;
    logic                  hit;
    logic                  empty;

    // upper 32 bits of the 64-bit product modulo 2^64, from three 32x32 partial products
    always_comb
    begin
        priority if (cmd.hash0)
        begin
            mul_a = name_reg[31:0];
            mul_b = HASH_MULT[31:0];
        end
        else if (cmd.hash1)
        begin
            mul_a = name_reg[63:32];
            mul_b = HASH_MULT[31:0];
        end
        else
        begin
            mul_a = name_reg[31:0];
            mul_b = HASH_MULT[63:32];
        end
    end

    assign mul_p    = mul_a * mul_b;
    assign hash_sum = sum_reg + mul_p[31:0];

    nlt_ram #(
        .WIDTH ($bits(nlt_entry_t)),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wr_entry),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (rd_entry)
    );

    assign empty = !rd_entry.used;
    assign hit   = rd_entry.used && (rd_entry.name == name_reg);

    always_comb
    begin
        do_write    = 1'b0;
        new_lw      = LW_FREE;
        res_status  = ST_NOT_FOUND;
        res_slot_ok = 1'b0;
        if (cmd_reg == CMD_ACQUIRE)
        begin
            priority if (empty)
            begin
                do_write    = 1'b1;
                new_lw      = LW_LOCKED;
                res_status  = ST_GRANTED;
                res_slot_ok = 1'b1;
            end
            else if (hit)
            begin
                do_write    = 1'b1;
                res_slot_ok = 1'b1;
                if (rd_entry.lw == LW_FREE)
                begin
                    new_lw     = LW_LOCKED;
                    res_status = ST_GRANTED;
                end
                else
                begin
                    new_lw     = LW_WAIT;
                    res_status = ST_BUSY;
                end
            end
            else
            begin
                res_status = ST_FULL;
            end
        end
        else if (hit)
        begin
            do_write    = 1'b1;
            new_lw      = LW_FREE;
            res_slot_ok = 1'b1;
            res_status  = rd_entry.lw[1] ? ST_REL_WAKE : ST_REL_IDLE;
        end
    end

    always_comb
    begin
        if (cmd.clr_step)
        begin
            we       = 1'b1;
            waddr    = clr_reg;
            wr_entry = '0;
        end
        else
        begin
            we            = cmd.finish && do_write;
            waddr         = idx_reg;
            wr_entry.used = 1'b1;
            wr_entry.lw   = new_lw;
            wr_entry.name = name_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= in_cmd;
            name_reg <= in_name;
        end
        if (cmd.hash0)
        begin
            prod_reg <= mul_p[63:32];
        end
        if (cmd.hash1)
        begin
            sum_reg <= prod_reg + mul_p[31:0];
        end
        if (cmd.hash2)
        begin
            idx_reg <= hash_sum[31 -: INDEX_BITS];
            cnt_reg <= '0;
        end
        else if (cmd.advance)
        begin
            idx_reg <= idx_reg + 1'b1;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_slot_ok ? idx_reg : '0;
        end
    end

    assign stat.clr_last   = (clr_reg == {INDEX_BITS{1'b1}});
    assign stat.hit        = hit;
    assign stat.empty      = empty;
    assign stat.last_probe = (cnt_reg == {INDEX_BITS{1'b1}});
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Testbench for named_lock_table: directed, random, stall and table-full tests against a scoreboard.
`timescale 1ns / 1ps
module tb_top;
    import nlt_pkg::*;

    localparam int unsigned INDEX_BITS = 10;
    localparam int unsigned TABLE_SIZE = 1 << INDEX_BITS;
    localparam logic [NAME_W-1:0] GOLDEN_MULT = 64'h9E37_79B9_7F4A_7C15;
    localparam int QUIET_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 2 * TABLE_SIZE + 16;
    localparam int RSP_HOLD_CYCLES = 300;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [INDEX_BITS-1:0] slot;
    } lock_reply_t;

    logic clk = 1'b0;
    logic rst_n;

    nlt_req_if req_if ();
    nlt_rsp_if #(.INDEX_BITS(INDEX_BITS)) rsp_if ();

    named_lock_table #(
        .INDEX_BITS(INDEX_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // predicted table contents
    bit                tbl_used [TABLE_SIZE];
    bit [NAME_W-1:0]   tbl_name [TABLE_SIZE];
    bit [1:0]          tbl_word [TABLE_SIZE];
    int                tbl_fill;

    lock_reply_t       replies_due [$];
    logic [NAME_W-1:0] lock_names [$];
    int                err_count;
    int                idle_pct;
    int                stall_pct;
    int                rsp_hold;
    bit                hold_req;
    bit                hold_ack;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [INDEX_BITS-1:0] home_slot(logic [NAME_W-1:0] name);
        logic [NAME_W-1:0] prod;
        prod = name * GOLDEN_MULT;
        return prod[NAME_W-1 -: INDEX_BITS];
    endfunction

    function automatic lock_reply_t predict_lock(logic cmd, logic [NAME_W-1:0] name);
        lock_reply_t rep;
        int unsigned start;
        int unsigned idx;
        bit hit;
        bit gap;
        start = 32'(home_slot(name));
        idx = 0;
        hit = 1'b0;
        gap = 1'b0;
        for (int unsigned i = 0; i < TABLE_SIZE && !hit && !gap; i++)
        begin
            idx = (start + i) % TABLE_SIZE;
            if (!tbl_used[idx])
                gap = 1'b1;
            else if (tbl_name[idx] == name)
                hit = 1'b1;
        end
        rep.slot = '0;
        if (cmd == CMD_ACQUIRE)
        begin
            if (!hit && !gap)
                rep.status = ST_FULL;
            else
            begin
                if (gap)
                begin
                    tbl_used[idx] = 1'b1;
                    tbl_name[idx] = name;
                    tbl_word[idx] = LW_FREE;
                    tbl_fill++;
                end
                rep.slot = idx[INDEX_BITS-1:0];
                if (tbl_word[idx] == LW_FREE)
                begin
                    tbl_word[idx] = LW_LOCKED;
                    rep.status = ST_GRANTED;
                end
                else
                begin
                    tbl_word[idx] = LW_WAIT;
                    rep.status = ST_BUSY;
                end
            end
        end
        else if (!hit)
            rep.status = ST_NOT_FOUND;
        else
        begin
            rep.status = (tbl_word[idx] >= LW_WAIT) ? ST_REL_WAKE : ST_REL_IDLE;
            rep.slot = idx[INDEX_BITS-1:0];
            tbl_word[idx] = LW_FREE;
        end
        return rep;
    endfunction

    // response first, then the request of the same edge
    always @(posedge clk)
    begin : lock_check
        lock_reply_t want;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    err_count++;
                    $error("unexpected response: status %0d slot_index %0d",
                           rsp_if.status, rsp_if.slot_index);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (rsp_if.status !== want.status)
                    begin
                        err_count++;
                        $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
                    end
                    if (rsp_if.slot_index !== want.slot)
                    begin
                        err_count++;
                        $error("slot_index: expected %0d, actual %0d",
                               want.slot, rsp_if.slot_index);
                    end
                end
            end
            if (req_if.valid && req_if.ready)
                replies_due.push_back(predict_lock(req_if.cmd, req_if.lock_name));
        end
    end

    // receiver: a toggle of hold_req starts a long hold-off counted here
    always @(negedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack = hold_req;
            rsp_hold = RSP_HOLD_CYCLES;
        end
        if (rsp_hold > 0)
        begin
            rsp_if.ready = 1'b0;
            rsp_hold--;
        end
        else
            rsp_if.ready = ($urandom_range(99) >= stall_pct);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_request(logic cmd, logic [NAME_W-1:0] name);
        while ($urandom_range(99) < idle_pct)
        begin
            req_if.valid = 1'b0;
            req_if.cmd = 1'($urandom_range(1));
            req_if.lock_name = {$urandom, $urandom};
            @(negedge clk);
        end
        req_if.valid = 1'b1;
        req_if.cmd = cmd;
        req_if.lock_name = name;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_replies();
        req_if.valid = 1'b0;
        while (replies_due.size() != 0)
            @(negedge clk);
    endtask

    // receiver settings change on the rising edge, away from the receiver process
    task automatic set_idling(int send_pct, int recv_pct);
        @(posedge clk);
        idle_pct = send_pct;
        stall_pct = recv_pct;
        @(negedge clk);
    endtask

    function automatic logic [NAME_W-1:0] name_for_slot(logic [INDEX_BITS-1:0] slot);
        logic [NAME_W-1:0] name;
        name = {$urandom, $urandom};
        while (home_slot(name) != slot)
            name = {$urandom, $urandom};
        return name;
    endfunction

    task automatic test_directed();
        logic [NAME_W-1:0] name_a;
        logic [NAME_W-1:0] name_b;
        logic [NAME_W-1:0] name_c;
        name_a = name_for_slot('1);
        name_b = name_for_slot('1);
        while (name_b == name_a)
            name_b = name_for_slot('1);
        name_c = name_for_slot('1);
        while (name_c == name_a || name_c == name_b)
            name_c = name_for_slot('1);
        set_idling(0, 0);
        send_request(CMD_RELEASE, '0);
        send_request(CMD_ACQUIRE, '0);
        send_request(CMD_ACQUIRE, '0);
        send_request(CMD_ACQUIRE, '0);
        send_request(CMD_RELEASE, '0);
        send_request(CMD_RELEASE, '0);
        send_request(CMD_ACQUIRE, '0);
        send_request(CMD_RELEASE, '0);
        send_request(CMD_ACQUIRE, '1);
        send_request(CMD_ACQUIRE, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(CMD_ACQUIRE, 64'h5555_5555_5555_5555);
        send_request(CMD_RELEASE, '1);
        // same home slot at the top of the table: wraps past slot zero
        send_request(CMD_ACQUIRE, name_a);
        send_request(CMD_ACQUIRE, name_b);
        send_request(CMD_RELEASE, name_c);
        send_request(CMD_ACQUIRE, name_b);
        send_request(CMD_RELEASE, name_b);
        send_request(CMD_RELEASE, name_a);
        wait_replies();
        lock_names.push_back('0);
        lock_names.push_back('1);
        lock_names.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        lock_names.push_back(64'h5555_5555_5555_5555);
        lock_names.push_back(name_a);
        lock_names.push_back(name_b);
    endtask

    task automatic test_random_traffic(int n_items, int send_pct, int recv_pct);
        logic [NAME_W-1:0] name;
        logic cmd;
        int unsigned pick;
        int unsigned span;
        set_idling(send_pct, recv_pct);
        repeat (n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                if ($urandom_range(3) == 0)
                    name = {52'd0, 12'($urandom_range(4095))};
                else
                    name = {$urandom, $urandom};
                cmd = CMD_ACQUIRE;
                lock_names.push_back(name);
            end
            else if (pick < 13)
            begin
                name = {$urandom, $urandom};
                cmd = CMD_RELEASE;
            end
            else
            begin
                span = lock_names.size();
                if ($urandom_range(1) == 0 && span > 16)
                    span = 16;
                name = lock_names[lock_names.size() - 1 - $urandom_range(span - 1)];
                cmd = ($urandom_range(1) == 0) ? CMD_ACQUIRE : CMD_RELEASE;
            end
            send_request(cmd, name);
        end
        wait_replies();
    endtask

    task automatic test_response_stall();
        set_idling(0, 0);
        @(posedge clk);
        hold_req = ~hold_req;
        @(negedge clk);
        repeat (8)
            send_request(1'($urandom_range(1)),
                         lock_names[$urandom_range(lock_names.size() - 1)]);
        wait_replies();
    endtask

    task automatic test_table_full();
        logic [NAME_W-1:0] seq_name;
        int unsigned fill_sent;
        set_idling(0, 0);
        seq_name = 64'd1;
        fill_sent = 0;
        // the fill walks through every idling phase
        while (tbl_fill < TABLE_SIZE)
        begin
            if (fill_sent == 256)
                set_idling(79, 0);
            else if (fill_sent == 512)
                set_idling(0, 79);
            else if (fill_sent == 768)
                set_idling(26, 26);
            send_request(CMD_ACQUIRE, seq_name);
            seq_name++;
            fill_sent++;
        end
        set_idling(26, 26);
        send_request(CMD_ACQUIRE, {$urandom | 32'h8000_0000, $urandom});
        send_request(CMD_RELEASE, {$urandom | 32'h8000_0000, $urandom});
        send_request(CMD_ACQUIRE, lock_names[0]);
        send_request(CMD_RELEASE, lock_names[0]);
        send_request(CMD_RELEASE, lock_names[0]);
        send_request(CMD_ACQUIRE, seq_name - 1);
        send_request(CMD_RELEASE, seq_name - 1);
        wait_replies();
    endtask

    initial
    begin
        idle_pct = 0;
        stall_pct = 0;
        req_if.valid = 1'b0;
        req_if.cmd = CMD_ACQUIRE;
        req_if.lock_name = '0;
        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_traffic(16, 0, 0);
        test_random_traffic(16, 79, 0);
        test_random_traffic(16, 0, 79);
        test_random_traffic(16, 26, 26);
        test_response_stall();
        test_table_full();

        wait_replies();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
